### design/pscu_pkg.sv
// Shared types, constants and fixed-point helpers for the sensor compensation pipeline.
`timescale 1ns / 1ps
package pscu_pkg;

  typedef enum logic [2:0] {
    REG_CAL_TEMP     = 3'd0,
    REG_CAL_PRES_LO  = 3'd1,
    REG_CAL_PRES_HI  = 3'd2,
    REG_CAL_MIXED    = 3'd3,
    REG_CAL_HUM      = 3'd4
  } cfg_reg_e;

  // Calibration coefficients, each widened to 32 bits as the arithmetic uses them.
  typedef struct packed {
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] t3;
    logic [31:0] p1;
    logic [31:0] p2;
    logic [31:0] p3;
    logic [31:0] p4;
    logic [31:0] p5;
    logic [31:0] p6;
    logic [31:0] p7;
    logic [31:0] p8;
    logic [31:0] p9;
    logic [31:0] h1;
    logic [31:0] h2;
    logic [31:0] h3;
    logic [31:0] h4;
    logic [31:0] h5;
    logic [31:0] h6;
  } cal_t;

  localparam int unsigned TF_LAT    = 4;   // raw sample to fine temperature
  localparam int unsigned DIV_W     = 32;  // divider width, one bit per stage
  localparam int unsigned PRES_LAT  = 6 + DIV_W + 4;
  localparam int unsigned HUM_LAT   = 13;
  localparam int unsigned TOTAL_LAT = TF_LAT + PRES_LAT;

  localparam logic [31:0] PRES_OFS     = 32'd64000;
  localparam logic [31:0] PRES_BASE    = 32'd1048576;
  localparam logic [31:0] PRES_SCALE   = 32'd3125;
  localparam logic [31:0] HUM_T_OFS    = 32'd76800;
  localparam logic [31:0] HUM_RND      = 32'd16384;
  localparam logic [31:0] HUM_BIAS     = 32'd2097152;
  localparam logic [31:0] HUM_LIM      = 32'd419430400;
  localparam logic [16:0] HUM_MAX      = 17'd102400;

  function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned n);
    asr32 = 32'($signed(x) >>> n);
  endfunction

  // Signed divide by 2^n, truncating toward zero.
  function automatic logic [31:0] sdiv_p2(input logic [31:0] x, input int unsigned n);
    logic [31:0] neg;
    neg = 32'd0 - x;
    sdiv_p2 = x[31] ? (32'd0 - (neg >> n)) : (x >> n);
  endfunction

endpackage

### design/pscu_div.sv
// Pipelined restoring unsigned divider, one quotient bit per stage.
`timescale 1ns / 1ps
module pscu_div
  import pscu_pkg::*;
(
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [DIV_W-1:0]  dvd_i,
  input  logic [DIV_W-1:0]  dvs_i,
  input  logic              tag_i,
  output logic [DIV_W-1:0]  quo_o,
  output logic [DIV_W-1:0]  dvs_o,
  output logic              tag_o
);

  logic [DIV_W-1:0] rem_q [DIV_W-1];
  logic [DIV_W-1:0] dq_q  [DIV_W];
  logic [DIV_W-1:0] d_q   [DIV_W];
  logic             tag_q [DIV_W];

  for (genvar k = 0; k < DIV_W; k++) begin : g_st
    logic [DIV_W-1:0] rem_in, dq_in, d_in;
    logic             tag_in;
    logic [DIV_W+1:0] trial;
    logic [DIV_W-1:0] rem_d, dq_d;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign dq_in  = dvd_i;
      assign d_in   = dvs_i;
      assign tag_in = tag_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign dq_in  = dq_q[k-1];
      assign d_in   = d_q[k-1];
      assign tag_in = tag_q[k-1];
    end

    assign trial = {1'b0, rem_in, dq_in[DIV_W-1]} - {2'b00, d_in};
    assign rem_d = trial[DIV_W+1] ? {rem_in[DIV_W-2:0], dq_in[DIV_W-1]} : trial[DIV_W-1:0];
    assign dq_d  = {dq_in[DIV_W-2:0], ~trial[DIV_W+1]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dq_q[k]  <= dq_d;
        d_q[k]   <= d_in;
        tag_q[k] <= tag_in;
      end
    end

    if (k < DIV_W - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k] <= rem_d;
        end
      end
    end
  end

  assign quo_o = dq_q[DIV_W-1];
  assign dvs_o = d_q[DIV_W-1];
  assign tag_o = tag_q[DIV_W-1];

endmodule

### design/pscu_temp.sv
// Fine temperature pipeline, four stages; carries the other raw fields along.
`timescale 1ns / 1ps
module pscu_temp
  import pscu_pkg::*;
(
  input  logic        clk_i,
  input  logic        en_i,
  input  cal_t        cal_i,
  input  logic [19:0] ut_i,
  input  logic [19:0] up_i,
  input  logic [15:0] uh_i,
  output logic [31:0] tf_o,
  output logic [19:0] up_o,
  output logic [15:0] uh_o
);

  logic [31:0] x_q, c_q, pa_q, cc_q, a_q, m_q, tf_q;
  logic [19:0] up_q [TF_LAT];
  logic [15:0] uh_q [TF_LAT];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q  <= ({12'd0, ut_i} >> 3) - (cal_i.t1 << 1);
      c_q  <= ({12'd0, ut_i} >> 4) - cal_i.t1;
      pa_q <= x_q * cal_i.t2;
      cc_q <= c_q * c_q;
      a_q  <= asr32(pa_q, 11);
      m_q  <= asr32(cc_q, 12) * cal_i.t3;
      tf_q <= a_q + asr32(m_q, 14);
      up_q[0] <= up_i;
      uh_q[0] <= uh_i;
      for (int i = 1; i < TF_LAT; i++) begin
        up_q[i] <= up_q[i-1];
        uh_q[i] <= uh_q[i-1];
      end
    end
  end

  assign tf_o = tf_q;
  assign up_o = up_q[TF_LAT-1];
  assign uh_o = uh_q[TF_LAT-1];

endmodule

### design/pscu_pres.sv
// Pressure pipeline: coefficient terms, pipelined divide, then the correction terms.
`timescale 1ns / 1ps
module pscu_pres
  import pscu_pkg::*;
(
  input  logic        clk_i,
  input  logic        en_i,
  input  cal_t        cal_i,
  input  logic [31:0] tf_i,
  input  logic [19:0] up_i,
  output logic [31:0] pres_o
);

  logic [31:0] a1_q, c1_q, cc2_q, ap5_q, p2a_q, ap5b_q, p2ab_q;
  logic [31:0] b13_q, t13_q, b4_q, a4_q, a5m_q, bs5_q, dvs_q, num_q;
  logic [19:0] up_q [5];
  logic [31:0] dvd, quo, dvs_end;
  logic        big_end;
  logic [31:0] p0_q, cc_q, pr8_q, pr_q, pr2_q, a_q, b_q;
  logic        z0_q, z1_q, z2_q;
  logic [31:0] res_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a1_q   <= asr32(tf_i, 1) - PRES_OFS;
      c1_q   <= asr32(asr32(tf_i, 1) - PRES_OFS, 2);
      up_q[0] <= up_i;
      for (int i = 1; i < 5; i++) begin
        up_q[i] <= up_q[i-1];
      end
      cc2_q  <= c1_q * c1_q;
      ap5_q  <= a1_q * cal_i.p5;
      p2a_q  <= cal_i.p2 * a1_q;
      b13_q  <= asr32(cc2_q, 11) * cal_i.p6;
      t13_q  <= cal_i.p3 * asr32(cc2_q, 13);
      ap5b_q <= ap5_q;
      p2ab_q <= p2a_q;
      b4_q   <= asr32(b13_q + (ap5b_q << 1), 2) + (cal_i.p4 << 16);
      a4_q   <= asr32(asr32(t13_q, 3) + asr32(p2ab_q, 1), 18);
      a5m_q  <= (32'd32768 + a4_q) * cal_i.p1;
      bs5_q  <= asr32(b4_q, 12);
      dvs_q  <= asr32(a5m_q, 15);
      num_q  <= ((PRES_BASE - {12'd0, up_q[4]}) - bs5_q) * PRES_SCALE;
    end
  end

  // Large numerators divide first and double after, so nothing shifts out.
  assign dvd = num_q[31] ? num_q : (num_q << 1);

  pscu_div u_div (
    .clk_i (clk_i),
    .en_i  (en_i),
    .dvd_i (dvd),
    .dvs_i (dvs_q),
    .tag_i (num_q[31]),
    .quo_o (quo),
    .dvs_o (dvs_end),
    .tag_o (big_end)
  );

  // pr2_q is the quotient copy aligned with a_q/b_q
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p0_q  <= big_end ? (quo << 1) : quo;
      z0_q  <= (dvs_end == 32'd0);
      cc_q  <= (p0_q >> 3) * (p0_q >> 3);
      pr8_q <= (p0_q >> 2) * cal_i.p8;
      pr_q  <= p0_q;
      z1_q  <= z0_q;
      a_q   <= cal_i.p9 * (cc_q >> 13);
      b_q   <= asr32(pr8_q, 13);
      pr2_q <= pr_q;
      z2_q  <= z1_q;
      res_q <= z2_q ? 32'd0 : (pr2_q + asr32(asr32(a_q, 12) + b_q + cal_i.p7, 4));
    end
  end

  assign pres_o = res_q;

endmodule

### design/pscu_hum.sv
// Humidity pipeline, thirteen stages.
`timescale 1ns / 1ps
module pscu_hum
  import pscu_pkg::*;
(
  input  logic        clk_i,
  input  logic        en_i,
  input  cal_t        cal_i,
  input  logic [31:0] tf_i,
  input  logic [15:0] uh_i,
  output logic [16:0] hum_o
);

  logic [31:0] a1_q, bc1_q, d2_q, ah6_q, ah3_q, bc2_q;
  logic [31:0] e3_q, b3_q, c3_q, m4_q, e4_q, d5_q, e5_q, dh6_q, e6_q;
  logic [31:0] b7_q, e7_q, c8_q, s9_q, c9_q, sq_q, c10_q, d11_q, c11_q, dh1_q, c12_q;
  logic [16:0] hum_q;
  logic [31:0] e_fin, e_clamp, h_raw;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a1_q  <= tf_i - HUM_T_OFS;
      bc1_q <= ({16'd0, uh_i} << 14) - (cal_i.h4 << 20);
      d2_q  <= cal_i.h5 * a1_q;
      ah6_q <= a1_q * cal_i.h6;
      ah3_q <= a1_q * cal_i.h3;
      bc2_q <= bc1_q;
      e3_q  <= sdiv_p2((bc2_q - d2_q) + HUM_RND, 15);
      b3_q  <= sdiv_p2(ah6_q, 10);
      c3_q  <= sdiv_p2(ah3_q, 11) + 32'd32768;
      m4_q  <= b3_q * c3_q;
      e4_q  <= e3_q;
      d5_q  <= sdiv_p2(m4_q, 10) + HUM_BIAS;
      e5_q  <= e4_q;
      dh6_q <= d5_q * cal_i.h2;
      e6_q  <= e5_q;
      b7_q  <= sdiv_p2(dh6_q + 32'd8192, 14);
      e7_q  <= e6_q;
      c8_q  <= e7_q * b7_q;
      s9_q  <= sdiv_p2(c8_q, 15);
      c9_q  <= c8_q;
      sq_q  <= s9_q * s9_q;
      c10_q <= c9_q;
      d11_q <= sdiv_p2(sq_q, 7);
      c11_q <= c10_q;
      dh1_q <= d11_q * cal_i.h1;
      c12_q <= c11_q;
      hum_q <= (h_raw > {15'd0, HUM_MAX}) ? HUM_MAX : h_raw[16:0];
    end
  end

  // clamp to 0..100 % before the final scale
  assign e_fin   = c12_q - sdiv_p2(dh1_q, 4);
  assign e_clamp = e_fin[31] ? 32'd0 : ((e_fin > HUM_LIM) ? HUM_LIM : e_fin);
  assign h_raw   = e_clamp >> 12;
  assign hum_o   = hum_q;

endmodule

### design/pth_sensor_compensation_unit.sv
// Top level of the pressure / temperature / humidity compensation pipeline.
`timescale 1ns / 1ps
// Compensates one raw sample triple per cycle while the output is not
// stalled. Four stages form the fine temperature, the pressure path then
// takes 42 stages, most of them the 32-stage bit-per-stage divider, which
// sets the latency. Humidity and temperature run beside it and are delayed
// to line up. A stall on the output freezes the whole pipeline; the input
// is stalled only while a finished item waits at the output, so throughput
// is one item per cycle. Calibration registers are written through the cfg
// port; the user must write them only while the block is idle, which the
// block does not enforce. Writes to unknown indexes are ignored, and
// cfg_ready_o is always high. A zero pressure divisor gives pressure 0.
module pth_sensor_compensation_unit
  import pscu_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [19:0]        raw_pressure_i,
  input  logic [19:0]        raw_temperature_i,
  input  logic [15:0]        raw_humidity_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] temperature_o,
  output logic [31:0]        pressure_o,
  output logic [16:0]        humidity_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [63:0]        cfg_data_i
);

  localparam int unsigned HUM_PAD = PRES_LAT - HUM_LAT;

  logic [47:0] cal_t_q, cal_mx_q;
  logic [63:0] cal_pl_q, cal_ph_q;
  logic [31:0] cal_h_q;
  cal_t        cal;

  logic                 en;
  logic [TOTAL_LAT-1:0] v_q;
  logic [31:0]          tf;
  logic [19:0]          up_tf;
  logic [15:0]          uh_tf;
  logic [31:0]          pres;
  logic [16:0]          hum;
  logic [31:0]          temp_d;
  logic [31:0]          temp_q [PRES_LAT];
  logic [16:0]          hum_q  [HUM_PAD];

  // Calibration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_t_q  <= '0;
      cal_pl_q <= '0;
      cal_ph_q <= '0;
      cal_mx_q <= '0;
      cal_h_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_CAL_TEMP:    cal_t_q  <= cfg_data_i[47:0];
        REG_CAL_PRES_LO: cal_pl_q <= cfg_data_i;
        REG_CAL_PRES_HI: cal_ph_q <= cfg_data_i;
        REG_CAL_MIXED:   cal_mx_q <= cfg_data_i[47:0];
        REG_CAL_HUM:     cal_h_q  <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // Unpack into sign- or zero-extended coefficients
  always_comb begin
    cal.t1 = {16'd0, cal_t_q[15:0]};
    cal.t2 = {{16{cal_t_q[31]}}, cal_t_q[31:16]};
    cal.t3 = {{16{cal_t_q[47]}}, cal_t_q[47:32]};
    cal.p1 = {16'd0, cal_pl_q[15:0]};
    cal.p2 = {{16{cal_pl_q[31]}}, cal_pl_q[31:16]};
    cal.p3 = {{16{cal_pl_q[47]}}, cal_pl_q[47:32]};
    cal.p4 = {{16{cal_pl_q[63]}}, cal_pl_q[63:48]};
    cal.p5 = {{16{cal_ph_q[15]}}, cal_ph_q[15:0]};
    cal.p6 = {{16{cal_ph_q[31]}}, cal_ph_q[31:16]};
    cal.p7 = {{16{cal_ph_q[47]}}, cal_ph_q[47:32]};
    cal.p8 = {{16{cal_ph_q[63]}}, cal_ph_q[63:48]};
    cal.p9 = {{16{cal_mx_q[15]}}, cal_mx_q[15:0]};
    cal.h1 = {24'd0, cal_mx_q[23:16]};
    cal.h2 = {{16{cal_mx_q[39]}}, cal_mx_q[39:24]};
    cal.h3 = {24'd0, cal_mx_q[47:40]};
    cal.h4 = {{20{cal_h_q[11]}}, cal_h_q[11:0]};
    cal.h5 = {{20{cal_h_q[23]}}, cal_h_q[23:12]};
    cal.h6 = {{24{cal_h_q[31]}}, cal_h_q[31:24]};
  end

  // Whole pipeline advances together; it holds only when the output item
  // is not taken.
  assign en         = !(v_q[TOTAL_LAT-1] && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[TOTAL_LAT-2:0], in_valid_i};
    end
  end

  pscu_temp u_temp (
    .clk_i (clk_i),
    .en_i  (en),
    .cal_i (cal),
    .ut_i  (raw_temperature_i),
    .up_i  (raw_pressure_i),
    .uh_i  (raw_humidity_i),
    .tf_o  (tf),
    .up_o  (up_tf),
    .uh_o  (uh_tf)
  );

  pscu_pres u_pres (
    .clk_i  (clk_i),
    .en_i   (en),
    .cal_i  (cal),
    .tf_i   (tf),
    .up_i   (up_tf),
    .pres_o (pres)
  );

  pscu_hum u_hum (
    .clk_i (clk_i),
    .en_i  (en),
    .cal_i (cal),
    .tf_i  (tf),
    .uh_i  (uh_tf),
    .hum_o (hum)
  );

  // Temperature in hundredths: (tf * 5 + 128) / 256, rounded toward zero
  assign temp_d = sdiv_p2((tf << 2) + tf + 32'd128, 8);

  always_ff @(posedge clk_i) begin
    if (en) begin
      temp_q[0] <= temp_d;
      for (int i = 1; i < PRES_LAT; i++) begin
        temp_q[i] <= temp_q[i-1];
      end
      hum_q[0] <= hum;
      for (int i = 1; i < HUM_PAD; i++) begin
        hum_q[i] <= hum_q[i-1];
      end
    end
  end

  assign out_valid_o   = v_q[TOTAL_LAT-1];
  assign temperature_o = $signed(temp_q[PRES_LAT-1]);
  assign pressure_o    = pres;
  assign humidity_o    = hum_q[HUM_PAD-1];

  // Humidity never leaves the clamped range
  a_hum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> humidity_o <= HUM_MAX)
    else $error("humidity out of range");

  // An accepted item enters the first valid stage
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> v_q[0])
    else $error("accepted item lost at entry");

  // A held output freezes every stage
  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(v_q))
    else $error("pipeline moved during output stall");

endmodule
